@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL. Each use stands on a line of its own
// and carries its own terminating semicolon.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("assertion failed");
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, cond)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/bmm_pkg.sv @@
`timescale 1ns / 1ps

package bmm_pkg;

	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 1024;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 11;
	localparam int MASK_W      = 9;
	localparam int POS_W       = 10;
	localparam int MIN_DIM     = 3;

	localparam logic [CFG_INDEX_W-1:0] REG_MODE          = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_ELEMENT_MASK  = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_CARE  = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_VALUE = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH   = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT  = 3'd5;

	localparam logic [1:0] MODE_DILATE = 2'd0;
	localparam logic [1:0] MODE_ERODE  = 2'd1;
	localparam logic [1:0] MODE_HMT    = 2'd2;

	// Keeps the left two columns of each window row after the shift.
	localparam logic [MASK_W-1:0] WIN_KEEP   = 9'h0DB;
	localparam logic [MASK_W-1:0] MASK_RESET = 9'h1FF;
	localparam logic [CFG_DATA_W-1:0] FRAME_DIM_RESET = 11'd1024;

	localparam int RES_FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W     = $clog2(RES_FIFO_DEPTH);
	localparam int FIFO_CNT_W     = $clog2(RES_FIFO_DEPTH + 1);

	typedef struct packed {
		logic [1:0]        mode;
		logic [MASK_W-1:0] element_mask;
		logic [MASK_W-1:0] pattern_care;
		logic [MASK_W-1:0] pattern_value;
	} morph_cfg_t;

	typedef struct packed {
		logic             black;
		logic             hit;
		logic [POS_W-1:0] column;
		logic [POS_W-1:0] row;
		logic             done;
	} res_item_t;

	typedef struct packed {
		logic black;
		logic hit;
	} pix_result_t;

	// Which window cells fall inside the frame, from the top, bottom, left and right edge tests.
	function automatic logic [MASK_W-1:0] make_inside(input logic top_ok, input logic bot_ok,
			input logic left_ok, input logic right_ok);
		logic [2:0]        rows;
		logic [2:0]        cols;
		logic [MASK_W-1:0] m;
		rows = {bot_ok, 1'b1, top_ok};
		cols = {right_ok, 1'b1, left_ok};
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				m[i*3+j] = rows[i] & cols[j];
			end
		end
		return m;
	endfunction

	function automatic pix_result_t morph_eval(input logic [MASK_W-1:0] win,
			input logic [MASK_W-1:0] in_frame, input logic interior, input morph_cfg_t cfg);
		logic [MASK_W-1:0] blk;
		logic [MASK_W-1:0] mirrored;
		pix_result_t       res;
		blk = win & in_frame;
		for (int k = 0; k < MASK_W; k++) begin
			mirrored[k] = cfg.element_mask[MASK_W-1-k];
		end
		res.black = win[4];
		res.hit   = 1'b0;
		unique case (cfg.mode)
			MODE_DILATE: begin
				res.black = win[4] | (|(blk & mirrored));
			end
			MODE_ERODE: begin
				res.black = win[4] & ((cfg.element_mask & ~in_frame) == '0)
					& ((cfg.element_mask & ~blk) == '0);
			end
			MODE_HMT: begin
				res.hit = interior & ((((~blk) ^ cfg.pattern_value) & cfg.pattern_care) == '0);
			end
			default: begin
				res.black = win[4];
			end
		endcase
		return res;
	endfunction

endpackage

@@ rtl/binary_morphology_3x3.sv @@
// A result is queued after the item completing its 3x3 neighbourhood is taken (one row
// below and one column right, or below in the last column, or a flush item), then leaves
// on res_valid. Throughput: one item per cycle unless stalled; a row's last item gives two
// results, the next none, and a four-entry queue evens this out. The line memory gives one
// read a cycle. Reset: registers to their defaults, counters and window cleared. The line
// memory is not cleared; rows not yet written in this frame lie outside it and are masked.
`timescale 1ns / 1ps

module binary_morphology_3x3 #(
	parameter int MAX_WIDTH  = bmm_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = bmm_pkg::MAX_HEIGHT_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [bmm_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [bmm_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              pix_valid,
	output logic                              pix_stall,
	input  logic                              kind,
	input  logic                              pixel_black,
	output logic                              res_valid,
	input  logic                              res_stall,
	output logic                              out_black,
	output logic                              hmt_hit,
	output logic [bmm_pkg::POS_W-1:0]         out_column,
	output logic [bmm_pkg::POS_W-1:0]         out_row,
	output logic                              frame_done
);

	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int HW    = $clog2(MAX_HEIGHT + 1);
	localparam int WH_W  = (WW > HW) ? WW : HW;
	localparam int DIM_W = (WH_W > bmm_pkg::CFG_DATA_W) ? WH_W : bmm_pkg::CFG_DATA_W;

	bmm_pkg::morph_cfg_t               cfg_q;
	logic [WW-1:0]                     width_q;
	logic [HW-1:0]                     height_q;
	logic                              restart;
	logic                              push_a;
	logic                              push_b;
	bmm_pkg::res_item_t                item_a;
	bmm_pkg::res_item_t                item_b;
	bmm_pkg::res_item_t                head;
	logic [bmm_pkg::FIFO_CNT_W-1:0]    fifo_count;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [bmm_pkg::CFG_DATA_W-1:0] v,
			input logic [DIM_W-1:0] hi);
		logic [DIM_W-1:0] ext;
		ext = DIM_W'(v);
		if (ext < DIM_W'(bmm_pkg::MIN_DIM)) begin
			return DIM_W'(bmm_pkg::MIN_DIM);
		end else if (ext > hi) begin
			return hi;
		end
		return ext;
	endfunction

	assign restart = cfg_write
		&& (cfg_index == bmm_pkg::REG_FRAME_WIDTH || cfg_index == bmm_pkg::REG_FRAME_HEIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode          <= bmm_pkg::MODE_DILATE;
			cfg_q.element_mask  <= bmm_pkg::MASK_RESET;
			cfg_q.pattern_care  <= '0;
			cfg_q.pattern_value <= '0;
			width_q  <= WW'(clamp_dim(bmm_pkg::FRAME_DIM_RESET, DIM_W'(MAX_WIDTH)));
			height_q <= HW'(clamp_dim(bmm_pkg::FRAME_DIM_RESET, DIM_W'(MAX_HEIGHT)));
		end else if (cfg_write) begin
			unique case (cfg_index)
				bmm_pkg::REG_MODE: begin
					cfg_q.mode <= cfg_data[1:0];
				end
				bmm_pkg::REG_ELEMENT_MASK: begin
					cfg_q.element_mask <= cfg_data[bmm_pkg::MASK_W-1:0];
				end
				bmm_pkg::REG_PATTERN_CARE: begin
					cfg_q.pattern_care <= cfg_data[bmm_pkg::MASK_W-1:0];
				end
				bmm_pkg::REG_PATTERN_VALUE: begin
					cfg_q.pattern_value <= cfg_data[bmm_pkg::MASK_W-1:0];
				end
				bmm_pkg::REG_FRAME_WIDTH: begin
					width_q <= WW'(clamp_dim(cfg_data, DIM_W'(MAX_WIDTH)));
				end
				bmm_pkg::REG_FRAME_HEIGHT: begin
					height_q <= HW'(clamp_dim(cfg_data, DIM_W'(MAX_HEIGHT)));
				end
				default: begin
				end
			endcase
		end
	end

	bmm_window #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_window (
		.clk        (clk),
		.arst_n     (arst_n),
		.restart    (restart),
		.cfg        (cfg_q),
		.frame_w    (width_q),
		.frame_h    (height_q),
		.pix_valid  (pix_valid),
		.pix_stall  (pix_stall),
		.kind       (kind),
		.pixel_black(pixel_black),
		.fifo_count (fifo_count),
		.push_a     (push_a),
		.item_a     (item_a),
		.push_b     (push_b),
		.item_b     (item_b)
	);

	bmm_result_fifo u_result_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_a   (push_a),
		.item_a   (item_a),
		.push_b   (push_b),
		.item_b   (item_b),
		.count    (fifo_count),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.head     (head)
	);

	assign out_black  = head.black;
	assign hmt_hit    = head.hit;
	assign out_column = head.column;
	assign out_row    = head.row;
	assign frame_done = head.done;

endmodule

@@ rtl/bmm_ram.sv @@
`timescale 1ns / 1ps

module bmm_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

@@ rtl/bmm_window.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bmm_window #(
	parameter int MAX_WIDTH  = bmm_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = bmm_pkg::MAX_HEIGHT_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                restart,
	input  bmm_pkg::morph_cfg_t                 cfg,
	input  logic [$clog2(MAX_WIDTH+1)-1:0]      frame_w,
	input  logic [$clog2(MAX_HEIGHT+1)-1:0]     frame_h,
	input  logic                                pix_valid,
	output logic                                pix_stall,
	input  logic                                kind,
	input  logic                                pixel_black,
	input  logic [bmm_pkg::FIFO_CNT_W-1:0]      fifo_count,
	output logic                                push_a,
	output bmm_pkg::res_item_t                  item_a,
	output logic                                push_b,
	output bmm_pkg::res_item_t                  item_b
);

	localparam int CW     = $clog2(MAX_WIDTH);
	localparam int WW     = $clog2(MAX_WIDTH + 1);
	localparam int RW     = $clog2(MAX_HEIGHT + 1);
	localparam int FILL_W = bmm_pkg::FIFO_CNT_W + 1;

	logic [CW-1:0]               col_q;
	logic [RW-1:0]               row_q;
	logic [bmm_pkg::MASK_W-1:0]  window_q;

	logic                        valid_s1;
	logic                        blk_s1;
	logic                        last_s1;
	logic [CW-1:0]               col_s1;
	logic [RW-1:0]               row_s1;

	logic                        pix_accept;
	logic                        is_last;
	logic                        pix_blk;
	logic [1:0]                  line_rd;
	logic                        emit_a;
	logic                        emit_b;
	logic [FILL_W-1:0]           fill;
	logic                        room;
	logic                        adv;
	logic [bmm_pkg::MASK_W-1:0]  win_a;
	logic [bmm_pkg::MASK_W-1:0]  win_b;
	logic                        top_ok;
	logic                        bot_ok;
	logic                        left_a;
	logic [RW-1:0]               orow;
	logic [CW-1:0]               ocol_a;
	logic [CW-1:0]               ocol_b;
	bmm_pkg::pix_result_t        res_a;
	bmm_pkg::pix_result_t        res_b;

	assign pix_accept = pix_valid & ~pix_stall;
	assign is_last    = (WW'(col_q) == frame_w - WW'(1));
	// Rows at or past the frame height are the flush row and read as white.
	assign pix_blk    = (row_q < frame_h) & ~kind & pixel_black;

	// Each line memory entry holds the row above (bit 1) and the current row (bit 0).
	bmm_ram #(
		.WIDTH(2),
		.DEPTH(MAX_WIDTH)
	) u_line_ram (
		.clk    (clk),
		.wr_en  (adv),
		.wr_addr(col_s1),
		.wr_data({line_rd[0], blk_s1}),
		.rd_en  (pix_accept),
		.rd_addr(col_q),
		.rd_data(line_rd)
	);

	assign emit_a = (row_s1 != '0) & (col_s1 != '0);
	assign emit_b = last_s1 & (row_s1 != '0);
	assign fill   = FILL_W'(fifo_count) + FILL_W'(emit_a) + FILL_W'(emit_b);
	assign room   = (fill <= FILL_W'(bmm_pkg::RES_FIFO_DEPTH));
	assign adv    = valid_s1 & room;
	assign pix_stall = valid_s1 & ~room;
	assign push_a = adv & emit_a;
	assign push_b = adv & emit_b;

	assign win_a = ((window_q >> 1) & bmm_pkg::WIN_KEEP)
		| {blk_s1, 2'b00, line_rd[0], 2'b00, line_rd[1], 2'b00};
	assign win_b = (win_a >> 1) & bmm_pkg::WIN_KEEP;

	assign orow   = row_s1 - RW'(1);
	assign ocol_a = col_s1 - CW'(1);
	assign ocol_b = CW'(frame_w - WW'(1));
	assign top_ok = (row_s1 >= RW'(2));
	assign bot_ok = (row_s1 < frame_h);
	assign left_a = (col_s1 >= CW'(2));

	assign res_a = bmm_pkg::morph_eval(win_a,
		bmm_pkg::make_inside(top_ok, bot_ok, left_a, 1'b1), top_ok & bot_ok & left_a, cfg);
	// The last column of a row is never interior, as its right neighbour is off the frame.
	assign res_b = bmm_pkg::morph_eval(win_b,
		bmm_pkg::make_inside(top_ok, bot_ok, 1'b1, 1'b0), 1'b0, cfg);

	always_comb begin
		item_a.black  = res_a.black;
		item_a.hit    = res_a.hit;
		item_a.column = bmm_pkg::POS_W'(ocol_a);
		item_a.row    = bmm_pkg::POS_W'(orow);
		item_a.done   = 1'b0;
		item_b.black  = res_b.black;
		item_b.hit    = res_b.hit;
		item_b.column = bmm_pkg::POS_W'(ocol_b);
		item_b.row    = bmm_pkg::POS_W'(orow);
		item_b.done   = (row_s1 == frame_h);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			window_q <= '0;
			valid_s1 <= 1'b0;
		end else if (restart) begin
			col_q    <= '0;
			row_q    <= '0;
			window_q <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (pix_accept) begin
				if (is_last) begin
					col_q <= '0;
					row_q <= (row_q >= frame_h) ? '0 : row_q + RW'(1);
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
			if (adv) begin
				window_q <= emit_b ? win_b : win_a;
			end
			if (pix_accept) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pix_accept) begin
			col_s1  <= col_q;
			row_s1  <= row_q;
			blk_s1  <= pix_blk;
			last_s1 <= is_last;
		end
	end

	`ASSERT_ALWAYS(a_col_in_frame, clk, arst_n, WW'(col_q) < frame_w)
	`ASSERT_ALWAYS(a_row_in_range, clk, arst_n, row_q <= frame_h)
	`ASSERT_IMPLIES(a_pair_at_row_end, clk, arst_n, push_b, push_a && last_s1)
	`ASSERT_NEXT(a_frame_wraps, clk, arst_n, pix_accept && is_last && row_q == frame_h, col_q == '0 && row_q == '0)

endmodule

@@ rtl/bmm_result_fifo.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bmm_result_fifo (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push_a,
	input  bmm_pkg::res_item_t             item_a,
	input  logic                           push_b,
	input  bmm_pkg::res_item_t             item_b,
	output logic [bmm_pkg::FIFO_CNT_W-1:0] count,
	output logic                           res_valid,
	input  logic                           res_stall,
	output bmm_pkg::res_item_t             head
);

	localparam int DEPTH  = bmm_pkg::RES_FIFO_DEPTH;
	localparam int PW     = bmm_pkg::FIFO_PTR_W;
	localparam int NW     = bmm_pkg::FIFO_CNT_W;
	localparam int FILL_W = NW + 1;

	bmm_pkg::res_item_t mem_q [DEPTH];
	logic [PW-1:0]      wr_ptr_q;
	logic [PW-1:0]      rd_ptr_q;
	logic [NW-1:0]      count_q;
	logic [PW-1:0]      slot_b;
	logic               pop;
	logic [FILL_W-1:0]  fill;

	assign res_valid = (count_q != '0);
	assign pop       = res_valid & ~res_stall;
	// The second item of a row end lands right behind the first.
	assign slot_b    = wr_ptr_q + PW'(push_a);
	assign head      = mem_q[rd_ptr_q];
	assign count     = count_q;
	assign fill      = FILL_W'(count_q) + FILL_W'(push_a) + FILL_W'(push_b);

	always_ff @(posedge clk) begin
		for (int i = 0; i < DEPTH; i++) begin
			if (push_a && wr_ptr_q == PW'(i)) begin
				mem_q[i] <= item_a;
			end
			if (push_b && slot_b == PW'(i)) begin
				mem_q[i] <= item_b;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PW'(push_a) + PW'(push_b);
			rd_ptr_q <= rd_ptr_q + PW'(pop);
			count_q  <= count_q + NW'(push_a) + NW'(push_b) - NW'(pop);
		end
	end

	`ASSERT_ALWAYS(a_count_in_range, clk, arst_n, count_q <= NW'(DEPTH))
	`ASSERT_ALWAYS(a_no_overflow, clk, arst_n, fill <= FILL_W'(DEPTH))

endmodule

@@ sim/morph_result_checker.sv @@
`timescale 1ns / 1ps

module morph_result_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [bmm_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [bmm_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            pix_valid,
	input  logic                            pix_stall,
	input  logic                            kind,
	input  logic                            pixel_black,
	input  logic                            res_valid,
	input  logic                            res_stall,
	input  logic                            out_black,
	input  logic                            hmt_hit,
	input  logic [bmm_pkg::POS_W-1:0]       out_column,
	input  logic [bmm_pkg::POS_W-1:0]       out_row,
	input  logic                            frame_done,
	output int                              mismatch_count,
	output int                              awaited_count,
	output int                              compared_count
);
	import bmm_pkg::*;

	localparam int LINE_LEN = MAX_WIDTH_DEF;

	logic [1:0]            mode_r;
	logic [MASK_W-1:0]     elem_r;
	logic [MASK_W-1:0]     care_r;
	logic [MASK_W-1:0]     value_r;
	logic [CFG_DATA_W-1:0] width_r;
	logic [CFG_DATA_W-1:0] height_r;

	logic                  line_up  [0:LINE_LEN-1];
	logic                  line_mid [0:LINE_LEN-1];
	logic [MASK_W-1:0]     window;
	int                    col_pos;
	int                    row_pos;

	res_item_t             awaited_pixels[$];

	function automatic int clamp_size(input logic [CFG_DATA_W-1:0] v, input int hi);
		int x;
		x = int'(v);
		if (x < MIN_DIM)
			return MIN_DIM;
		if (x > hi)
			return hi;
		return x;
	endfunction

	// Works out one result pixel from the window as it stands now.
	function automatic res_item_t judge_pixel(input int orow, input int ocol, input int w,
			input int h, input logic last);
		logic [MASK_W-1:0] in_frame;
		logic [MASK_W-1:0] blk;
		logic              res;
		logic              hit;
		res_item_t         item;
		int                i;
		int                j;
		int                k;
		in_frame = '0;
		for (i = 0; i < 3; i++) begin
			for (j = 0; j < 3; j++) begin
				if (orow + i - 1 >= 0 && orow + i - 1 < h && ocol + j - 1 >= 0
						&& ocol + j - 1 < w)
					in_frame[i*3+j] = 1'b1;
			end
		end
		blk = window & in_frame;
		res = window[4];
		hit = 1'b0;
		case (mode_r)
			MODE_DILATE: begin
				// The structuring element is applied mirrored about its centre.
				for (k = 0; k < MASK_W; k++) begin
					if (blk[k] && elem_r[MASK_W-1-k])
						res = 1'b1;
				end
			end
			MODE_ERODE: begin
				if ((elem_r & ~in_frame) != '0 || (elem_r & ~blk) != '0)
					res = 1'b0;
			end
			MODE_HMT: begin
				if (orow >= 1 && orow + 2 <= h && ocol >= 1 && ocol + 2 <= w)
					hit = ((((~blk) ^ value_r) & care_r) == '0);
			end
			default: begin
			end
		endcase
		item.black  = res;
		item.hit    = hit;
		item.column = POS_W'(ocol);
		item.row    = POS_W'(orow);
		item.done   = last;
		return item;
	endfunction

	task automatic take_pixel(input logic k, input logic px);
		int   w;
		int   h;
		int   r;
		int   c;
		logic blk;
		logic top;
		logic mid;
		w = clamp_size(width_r, MAX_WIDTH_DEF);
		h = clamp_size(height_r, MAX_HEIGHT_DEF);
		r = row_pos;
		c = col_pos;
		if (c >= w)
			c = w - 1;
		if (r > h)
			r = h;
		// Rows below the frame always read as white, whatever the item says.
		blk = (r < h && !k) ? px : 1'b0;
		top = line_up[c];
		mid = line_mid[c];
		line_up[c]  = mid;
		line_mid[c] = blk;
		window = ((window >> 1) & WIN_KEEP) | {blk, 2'b00, mid, 2'b00, top, 2'b00};
		if (r >= 1 && c >= 1)
			awaited_pixels.push_back(judge_pixel(r - 1, c - 1, w, h, 1'b0));
		if (c == w - 1) begin
			if (r >= 1) begin
				window = (window >> 1) & WIN_KEEP;
				awaited_pixels.push_back(judge_pixel(r - 1, w - 1, w, h, r == h));
			end
			c = 0;
			r = (r >= h) ? 0 : r + 1;
		end else begin
			c++;
		end
		col_pos = c;
		row_pos = r;
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_item_t want;
		if (!arst_n) begin
			mode_r   = MODE_DILATE;
			elem_r   = MASK_RESET;
			care_r   = '0;
			value_r  = '0;
			width_r  = FRAME_DIM_RESET;
			height_r = FRAME_DIM_RESET;
			for (int i = 0; i < LINE_LEN; i++) begin
				line_up[i]  = 1'b0;
				line_mid[i] = 1'b0;
			end
			window  = '0;
			col_pos = 0;
			row_pos = 0;
			awaited_pixels.delete();
			mismatch_count = 0;
			compared_count = 0;
			awaited_count  = 0;
		end else begin
			if (res_valid && !res_stall) begin
				if (awaited_pixels.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: result with none awaited:", $time,
							" black %0b hit %0b row %0d col %0d done %0b",
							out_black, hmt_hit, out_row, out_column, frame_done);
				end else begin
					want = awaited_pixels.pop_front();
					compared_count++;
					if (want.black !== out_black || want.hit !== hmt_hit
							|| want.column !== out_column || want.row !== out_row
							|| want.done !== frame_done) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("%0t: expected black %0b hit %0b row %0d col %0d done %0b,",
								$time, want.black, want.hit, want.row, want.column,
								want.done,
								" got black %0b hit %0b row %0d col %0d done %0b",
								out_black, hmt_hit, out_row, out_column, frame_done);
					end
				end
			end
			if (cfg_write) begin
				case (cfg_index)
					REG_MODE:          mode_r  = cfg_data[1:0];
					REG_ELEMENT_MASK:  elem_r  = cfg_data[MASK_W-1:0];
					REG_PATTERN_CARE:  care_r  = cfg_data[MASK_W-1:0];
					REG_PATTERN_VALUE: value_r = cfg_data[MASK_W-1:0];
					REG_FRAME_WIDTH: begin
						width_r = cfg_data;
						window  = '0;
						col_pos = 0;
						row_pos = 0;
					end
					REG_FRAME_HEIGHT: begin
						height_r = cfg_data;
						window   = '0;
						col_pos  = 0;
						row_pos  = 0;
					end
					default: begin
					end
				endcase
			end
			if (pix_valid && !pix_stall)
				take_pixel(kind, pixel_black);
			awaited_count = awaited_pixels.size();
		end
	end

endmodule

@@ sim/binary_morphology_3x3_tb.sv @@
`timescale 1ns / 1ps

module binary_morphology_3x3_tb;
	import bmm_pkg::*;

	localparam logic [1:0]             MODE_SPARE  = 2'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 3'd7;
	localparam int                     DRAIN_CYCLES = 10;
	localparam int                     RANDOM_ITEMS = 1250;
	localparam int                     TALL_CUT     = 60;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_write;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   pix_valid;
	logic                   pix_stall;
	logic                   kind;
	logic                   pixel_black;
	logic                   res_valid;
	logic                   res_stall;
	logic                   out_black;
	logic                   hmt_hit;
	logic [POS_W-1:0]       out_column;
	logic [POS_W-1:0]       out_row;
	logic                   frame_done;
	int                     mismatch_count;
	int                     awaited_count;
	int                     compared_count;

	int                     items_sent = 0;
	int                     frames_sent = 0;
	int                     burst_left = 0;
	bit                     gaps_on = 1'b1;
	int                     long_hold_cycles = 0;

	binary_morphology_3x3 DUT (.*);

	morph_result_checker checker_i (.*);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#6_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	// The receiver draws a new stall style each time the last one's run ends; a long hold-off overrides it.
	initial begin
		int style;
		int style_left;
		int phase;
		logic s;
		res_stall = 1'b0;
		style_left = 0;
		phase = 0;
		forever begin
			@(negedge clk);
			if (long_hold_cycles > 0) begin
				s = 1'b1;
				long_hold_cycles--;
			end else begin
				if (style_left == 0) begin
					style = $urandom_range(0, 3);
					style_left = 64;
				end
				style_left--;
				phase++;
				case (style)
					0: s = 1'b0;
					1: s = ($urandom_range(0, 3) == 0);
					2: s = ($urandom_range(0, 3) != 0);
					default: s = (phase % 5) < 2;
				endcase
			end
			res_stall <= s;
		end
	end

	task automatic send_item(input logic k, input logic p);
		int gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = gaps_on ? $urandom_range(0, 6) : 0;
		end
		burst_left--;
		@(negedge clk);
		if (gap > 0) begin
			pix_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		pix_valid   <= 1'b1;
		kind        <= k;
		pixel_black <= p;
		do
			@(posedge clk);
		while (pix_stall);
		items_sent++;
	endtask

	// Leaves the sender idle until every awaited pixel is out and the pipe is empty.
	task automatic wait_drain();
		@(negedge clk);
		pix_valid <= 1'b0;
		while (awaited_count != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_write <= 1'b0;
		@(negedge clk);
	endtask

	// Spare bits above each register's width are filled at random.
	task automatic configure(input logic [1:0] op, input logic [MASK_W-1:0] m,
			input logic [MASK_W-1:0] care, input logic [MASK_W-1:0] val,
			input logic [CFG_DATA_W-1:0] wd, input logic [CFG_DATA_W-1:0] hd);
		logic [CFG_DATA_W-1:0] spare;
		spare = CFG_DATA_W'($urandom);
		if ($urandom_range(0, 2) == 0)
			write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, spare);
		write_reg(REG_MODE, (spare & 11'h7FC) | op);
		write_reg(REG_ELEMENT_MASK, (spare & 11'h600) | m);
		write_reg(REG_PATTERN_CARE, (~spare & 11'h600) | care);
		write_reg(REG_PATTERN_VALUE, (spare & 11'h600) | val);
		write_reg(REG_FRAME_WIDTH, wd);
		write_reg(REG_FRAME_HEIGHT, hd);
	endtask

	function automatic logic [MASK_W-1:0] pick_mask();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			default: return MASK_W'($urandom);
		endcase
	endfunction

	// One frame plus its flush row; stop_at cuts it short, pause_at drains midway.
	task automatic send_frame(input int w, input int h, input int density, input int noise,
			input int stop_at, input int pause_at);
		int   n;
		logic k;
		logic p;
		n = 0;
		for (int r = 0; r <= h; r++) begin
			for (int c = 0; c < w; c++) begin
				if (n == stop_at)
					return;
				k = (r == h);
				if ($urandom_range(0, 99) < noise)
					k = ~k;
				p = ($urandom_range(0, 99) < density);
				send_item(k, p);
				n++;
				if (n == pause_at)
					wait_drain();
			end
		end
		frames_sent++;
	endtask

	task automatic send_directed(input logic [11:0] kinds, input logic [11:0] pixels);
		for (int i = 0; i < 12; i++)
			send_item(kinds[11-i], pixels[11-i]);
		frames_sent++;
	endtask

	initial begin
		logic [1:0]            op;
		logic [CFG_DATA_W-1:0] wd;
		logic [CFG_DATA_W-1:0] hd;
		int                    w;
		int                    h;
		int                    dens;
		int                    noise;
		int                    stop_at;
		int                    pause_at;
		int                    random_start;
		int                    frame_no;
		int                    sel;
		bit                    twice;
		cfg_write   = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		pix_valid   = 1'b0;
		kind        = 1'b0;
		pixel_black = 1'b0;
		arst_n      = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Dilation with the reset mask: a diagonal line touching both corners,
		// and a black item in the flush row that must read as white.
		write_reg(REG_FRAME_WIDTH, 11'd3);
		write_reg(REG_FRAME_HEIGHT, 11'd3);
		send_directed(12'b000_000_000_111, 12'b100_010_001_100);
		wait_drain();

		// Erosion of a black frame along the middle row, with sizes below the minimum,
		// a flush inside the image and a pixel inside the flush row.
		write_reg(REG_MODE, {9'h1FF, MODE_ERODE});
		write_reg(REG_ELEMENT_MASK, 11'h038);
		write_reg(REG_FRAME_WIDTH, 11'd0);
		write_reg(REG_FRAME_HEIGHT, 11'd2);
		send_directed(12'b000_000_001_101, 12'b111_111_111_011);
		wait_drain();

		// Height written above its range; only the top rows of the tall frame are sent.
		configure(MODE_ERODE, MASK_W'($urandom), pick_mask(), pick_mask(), 11'd1, 11'h7FF);
		send_frame(MIN_DIM, MAX_HEIGHT_DEF, 85, 2, TALL_CUT, -1);
		wait_drain();

		random_start = items_sent;
		frame_no = 0;
		while (items_sent - random_start < RANDOM_ITEMS) begin
			sel = $urandom_range(0, 9);
			if (frame_no == 0)
				op = MODE_HMT;
			else if (frame_no == 1)
				op = MODE_SPARE;
			else
				op = (sel < 3) ? MODE_DILATE : (sel < 6) ? MODE_ERODE : (sel < 9) ? MODE_HMT
					: MODE_SPARE;
			w = ($urandom_range(0, 7) == 0) ? $urandom_range(3, 40) : $urandom_range(3, 14);
			h = $urandom_range(3, 9);
			gaps_on = ($urandom_range(0, 2) != 0);
			if (frame_no == 3 || frame_no == 14) begin
				// Receiver holds off while the sender keeps offering, so the block backs up.
				w = 24;
				h = 8;
				gaps_on = 1'b0;
				long_hold_cycles = 300;
			end
			wd = (w == MIN_DIM && $urandom_range(0, 1)) ? CFG_DATA_W'($urandom_range(0, 2))
				: CFG_DATA_W'(w);
			hd = (h == MIN_DIM && $urandom_range(0, 1)) ? CFG_DATA_W'($urandom_range(0, 2))
				: CFG_DATA_W'(h);
			case ($urandom_range(0, 4))
				0: dens = 0;
				1: dens = 15;
				2: dens = 50;
				3: dens = 85;
				default: dens = 100;
			endcase
			noise = ($urandom_range(0, 4) == 0) ? 6 : 0;
			stop_at = ($urandom_range(0, 7) == 0) ? $urandom_range(1, w * (h + 1) - 1) : -1;
			pause_at = (frame_no == 2 || $urandom_range(0, 7) == 0)
				? $urandom_range(1, w * (h + 1) - 1) : -1;
			twice = (stop_at < 0 && $urandom_range(0, 4) == 0);
			if (frame_no == 0) begin
				// Hit-or-miss with the pattern registers kept as the tall-frame test configured them.
				write_reg(REG_MODE, {9'd0, op});
				write_reg(REG_FRAME_WIDTH, wd);
				write_reg(REG_FRAME_HEIGHT, hd);
			end else begin
				configure(op, pick_mask(), pick_mask(), pick_mask(), wd, hd);
			end
			send_frame(w, h, dens, noise, stop_at, pause_at);
			if (twice)
				send_frame(w, h, dens, noise, -1, -1);
			wait_drain();
			frame_no++;
		end
		gaps_on = 1'b1;
		wait_drain();

		$display("Sent %0d items, %0d whole frames, in all four modes with frames 3 to 40 wide,",
			items_sent, frames_sent);
		$display("clamped sizes, long output stalls and drains; %0d result pixels compared.",
			compared_count);
		if (mismatch_count == 0 && awaited_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/bmm_pkg.sv
rtl/bmm_ram.sv
rtl/bmm_window.sv
rtl/bmm_result_fifo.sv
rtl/binary_morphology_3x3.sv
sim/morph_result_checker.sv
sim/binary_morphology_3x3_tb.sv
